// ===== hdl/orsb_pkg.sv =====
`timescale 1ns / 1ps

package orsb_pkg;

  // Store geometry.
  localparam int unsigned MaxDepth = 1024;
  localparam int unsigned AddrW    = $clog2(MaxDepth);
  localparam int unsigned CntW     = 11;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned TotalW   = 32;

  // Request codes carried in req_type.
  localparam logic [1:0] ReqWrite = 2'd0;
  localparam logic [1:0] ReqRead  = 2'd1;
  localparam logic [1:0] ReqClear = 2'd2;

  // One request item.
  typedef struct packed {
    logic [1:0]                 req_type;
    logic signed [SampleW-1:0]  write_sample;
    logic                       last_of_call;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic signed [SampleW-1:0]  read_sample;
    logic                       read_valid;
    logic [CntW-1:0]            fill_level;
    logic [CntW-1:0]            space_left;
    logic [TotalW-1:0]          overwrite_total;
    logic                       call_done;
  } out_item_t;

endpackage

// ===== hdl/orsb_ram.sv =====
`timescale 1ns / 1ps

module orsb_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Single port: one write, one registered read, or both per cycle, at one address.
  // The read register keeps its value until the next read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/overwriting_sample_ring_buffer_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   in_item_i   (in_item_t)
// out       output     out_valid_o / out_stall_i out_item_o  (out_item_t)
// cfg       input      cfg_we_i                  cfg_wdata_i (ring capacity)
//
// A new transfer is accepted in every cycle in which the input does not stall.
// The result is registered and appears in the cycle after its request is
// accepted; its sample comes from the registered read port of the sample RAM.
// Reset empties the buffer, zeroes the overwrite total and sets capacity to 1024.
// The input stalls only while a result is held by a stalled output.

module overwriting_sample_ring_buffer_core
  import orsb_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_item_t        in_item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_item_o,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_wdata_i
);

  logic [CntW-1:0]    cap_q, cap_d;
  logic [AddrW-1:0]   rd_pos_q, rd_pos_d;
  logic [AddrW-1:0]   wr_pos_q, wr_pos_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [TotalW-1:0]  lost_q, lost_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          res_q, res_d;

  logic               accept;
  logic               ram_we;
  logic               ram_re;
  logic [AddrW-1:0]   ram_addr;
  logic [SampleW-1:0] ram_rdata;
  logic [CntW-1:0]    wr_next;
  logic [CntW-1:0]    rd_next;
  logic [AddrW-1:0]   wr_adv;
  logic [AddrW-1:0]   rd_adv;
  logic               full;
  logic               is_read;

  // A transfer is taken while the output register is empty or draining.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Position advance with wrap at the effective capacity.
  assign wr_next = {1'b0, wr_pos_q} + CntW'(1);
  assign rd_next = {1'b0, rd_pos_q} + CntW'(1);
  assign wr_adv  = (wr_next >= cap_q) ? '0 : wr_next[AddrW-1:0];
  assign rd_adv  = (rd_next >= cap_q) ? '0 : rd_next[AddrW-1:0];
  assign full    = (count_q >= cap_q);

  // Request decode and state update.
  always_comb begin
    cap_d    = cap_q;
    rd_pos_d = rd_pos_q;
    wr_pos_d = wr_pos_q;
    count_d  = count_q;
    lost_d   = lost_q;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    ram_addr = wr_pos_q;
    is_read  = 1'b0;

    if (cfg_we_i) begin
      // A new capacity empties the buffer; the overwrite total is kept.
      if (cfg_wdata_i == '0) begin
        cap_d = CntW'(1);
      end else if (cfg_wdata_i > CntW'(MaxDepth)) begin
        cap_d = CntW'(MaxDepth);
      end else begin
        cap_d = cfg_wdata_i;
      end
      rd_pos_d = '0;
      wr_pos_d = '0;
      count_d  = '0;
    end else if (accept) begin
      case (in_item_i.req_type)
        ReqWrite: begin
          ram_we   = 1'b1;
          wr_pos_d = wr_adv;
          if (full) begin
            // Full: the oldest sample is lost and the read side follows.
            rd_pos_d = wr_adv;
            if (lost_q != '1) begin
              lost_d = lost_q + TotalW'(1);
            end
          end else begin
            count_d = count_q + CntW'(1);
          end
        end
        ReqRead: begin
          if (count_q != '0) begin
            ram_re   = 1'b1;
            ram_addr = rd_pos_q;
            is_read  = 1'b1;
            rd_pos_d = rd_adv;
            count_d  = count_q - CntW'(1);
          end
        end
        ReqClear: begin
          rd_pos_d = '0;
          wr_pos_d = '0;
          count_d  = '0;
          lost_d   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Status fields of the result; the sample joins from the RAM read register.
  always_comb begin
    res_d                 = res_q;
    res_d.read_sample     = '0;
    res_d.read_valid      = is_read;
    res_d.fill_level      = count_d;
    res_d.space_left      = cap_q - count_d;
    res_d.overwrite_total = lost_d;
    res_d.call_done       = in_item_i.last_of_call;
  end

  // Output register occupancy.
  always_comb begin
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CntW'(MaxDepth);
      rd_pos_q    <= '0;
      wr_pos_q    <= '0;
      count_q     <= '0;
      lost_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cap_q       <= cap_d;
      rd_pos_q    <= rd_pos_d;
      wr_pos_q    <= wr_pos_d;
      count_q     <= count_d;
      lost_q      <= lost_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  // Sample store.
  orsb_ram #(
    .Width (SampleW),
    .Depth (MaxDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (in_item_i.write_sample),
    .rdata_o (ram_rdata)
  );

  // The RAM read register holds while the result waits, since no read
  // is issued until the output transfer completes.
  always_comb begin
    out_item_o = res_q;
    if (res_q.read_valid) begin
      out_item_o.read_sample = ram_rdata;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_count_in_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap_q)
    else $error("stored count exceeds capacity");

  a_pos_in_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, wr_pos_q} < cap_q) && ({1'b0, rd_pos_q} < cap_q))
    else $error("position beyond capacity");

  a_empty_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (rd_pos_q == wr_pos_q))
    else $error("empty buffer with differing positions");

  a_empty_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !cfg_we_i && (in_item_i.req_type == ReqRead) && (count_q == '0))
    |=> !out_item_o.read_valid)
    else $error("read from empty buffer reported valid");

  a_accept_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted request produced no result");
`endif

endmodule
